@@ rtl/wbps_pkg.sv @@
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern search unit.
// ----------------------------------------------------------------------------
package wbps_pkg;

  // Pattern depth and derived widths
  localparam int PatternMax = 64;
  localparam int LenW       = $clog2(PatternMax + 1);
  localparam int IdxW       = $clog2(PatternMax);

  // Fixed field widths
  localparam int CmdW       = 2;
  localparam int EntryIdxW  = 6;
  localparam int ByteW      = 8;
  localparam int CfgLenW    = 7;
  localparam int AddrW      = 32;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 32;

  // Item commands
  typedef enum logic [CmdW-1:0] {
    CmdLoad    = 2'd0,
    CmdScan    = 2'd1,
    CmdRestart = 2'd2
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternLength = 1'b0,
    CfgStartAddress  = 1'b1
  } cfg_idx_e;

  // Scan control shared by every cell
  typedef struct packed {
    logic scan;
    logic restart;
  } cell_ctl_t;

  // One result item
  typedef struct packed {
    logic             found;
    logic [AddrW-1:0] match_address;
  } res_item_t;

endpackage

@@ rtl/wbps_in_if.sv @@
// ----------------------------------------------------------------------------
// wbps_in_if
// Input item channel: command, pattern entry fields and scan byte fields.
// ----------------------------------------------------------------------------
interface wbps_in_if import wbps_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [CmdW-1:0]      command;
  logic [EntryIdxW-1:0] entry_index;
  logic [ByteW-1:0]     entry_value;
  logic                 entry_wildcard;
  logic [ByteW-1:0]     data_byte;
  logic                 data_last;

  modport source (
    output valid, command, entry_index, entry_value, entry_wildcard,
           data_byte, data_last,
    input  ready
  );

  modport sink (
    input  valid, command, entry_index, entry_value, entry_wildcard,
           data_byte, data_last,
    output ready
  );

endinterface

@@ rtl/wbps_out_if.sv @@
// ----------------------------------------------------------------------------
// wbps_out_if
// Result item channel: found flag and match address.
// ----------------------------------------------------------------------------
interface wbps_out_if import wbps_pkg::*; ();

  logic             valid;
  logic             ready;
  logic             found;
  logic [AddrW-1:0] match_address;

  modport source (
    output valid, found, match_address,
    input  ready
  );

  modport sink (
    input  valid, found, match_address,
    output ready
  );

endinterface

@@ rtl/wbps_cell.sv @@
// ----------------------------------------------------------------------------
// wbps_cell
// One pattern position: holds its expected byte, wildcard mark and the
// partial match bit for the alignment that ends at this position.
// ----------------------------------------------------------------------------
module wbps_cell import wbps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctl_t        ctl_i,
  input  logic             load_i,
  input  logic [ByteW-1:0] entry_value_i,
  input  logic             entry_wildcard_i,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             in_use_i,
  input  logic             prev_i,
  output logic             next_o,
  output logic             match_o
);

  logic [ByteW-1:0] pat_q;
  logic             wild_q;
  logic             match_d, match_q;
  logic             byte_ok;

  // Store the pattern entry on a load
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pat_q  <= entry_value_i;
      wild_q <= entry_wildcard_i;
    end
  end

  // Extend the neighbor's partial match by this byte
  assign byte_ok = wild_q || (pat_q == data_byte_i);

  always_comb begin
    match_d = match_q;
    if (ctl_i.restart) begin
      match_d = 1'b0;
    end else if (ctl_i.scan) begin
      match_d = prev_i && in_use_i && byte_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign next_o  = match_d;
  assign match_o = match_q;

endmodule

@@ rtl/wbps_out_buf.sv @@
// ----------------------------------------------------------------------------
// wbps_out_buf
// Two-entry result buffer that decouples the scan chain from the consumer.
// ----------------------------------------------------------------------------
module wbps_out_buf import wbps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  res_item_t  push_data_i,
  output logic       full_o,
  wbps_out_if.source result_o
);

  res_item_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop    = result_o.valid && result_o.ready;
  assign full_o = (count_q == 2'd2);

  // Write the pushed item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Present the oldest item
  assign result_o.valid         = (count_q != 2'd0);
  assign result_o.found         = mem_q[rd_ptr_q].found;
  assign result_o.match_address = mem_q[rd_ptr_q].match_address;

  // Never push into a full buffer
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("result pushed into full buffer");

  // Count rises by one on a push without a pop
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |=> (count_q == $past(count_q) + 2'd1))
    else $error("result count did not advance on push");

endmodule

@@ rtl/wildcard_byte_pattern_search_unit.sv @@
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_unit
// Wildcard byte pattern search of a byte stream, a byte per unstalled cycle.
// ----------------------------------------------------------------------------
// The unit takes one item every clock cycle while the result buffer has room:
// a pattern load, a restart or a scan byte. Each scan byte updates a row of
// PatternMax cells; every cell compares the byte against its own pattern
// entry and passes its partial match bit to the next cell, so every alignment
// is tracked at once. A result item (match address, or no-match on the last
// byte) is written to a two-entry output buffer at the edge that accepts the
// byte and is offered from the next cycle. Input ready drops only while that
// buffer holds two results. Pattern entries have no reset and must be loaded
// before a scan uses them.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search_unit import wbps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  wbps_in_if.sink             item_i,
  wbps_out_if.source          result_o
);

  logic [CfgLenW-1:0]    len_q;
  logic [AddrW-1:0]      start_q;
  logic [AddrW-1:0]      offset_q, offset_d;
  logic                  finished_q, finished_d;
  logic [LenW-1:0]       len_act;
  logic [IdxW-1:0]       top_idx;
  logic [PatternMax-1:0] next_vec, match_vec, in_use;
  logic                  accept, scan_go, restart_go, load_go;
  logic                  hit, push, full;
  cell_ctl_t             ctl;
  res_item_t             push_data;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= CfgLenW'(1);
      start_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgPatternLength: len_q   <= cfg_data_i[CfgLenW-1:0];
        CfgStartAddress:  start_q <= cfg_data_i[AddrW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the pattern length to the range 1..PatternMax
  always_comb begin
    if (len_q == '0) begin
      len_act = LenW'(1);
    end else if (int'(len_q) > PatternMax) begin
      len_act = LenW'(PatternMax);
    end else begin
      len_act = LenW'(len_q);
    end
  end

  assign top_idx = IdxW'(len_act - LenW'(1));

  // Decode the accepted item
  assign item_i.ready = !full;
  assign accept       = item_i.valid && item_i.ready;
  assign load_go      = accept && (cmd_e'(item_i.command) == CmdLoad);
  assign restart_go   = accept && (cmd_e'(item_i.command) == CmdRestart);
  assign scan_go      = accept && (cmd_e'(item_i.command) == CmdScan) && !finished_q;

  assign ctl.scan    = scan_go;
  assign ctl.restart = restart_go;

  // Row of match cells
  for (genvar i = 0; i < PatternMax; i++) begin : g_cell
    logic prev;
    logic load_sel;

    assign in_use[i] = (int'(len_act) > i);
    assign load_sel  = load_go && (int'(item_i.entry_index) == i);

    if (i == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_body
      assign prev = match_vec[i-1];
    end

    wbps_cell u_cell (
      .clk_i            (clk_i),
      .rst_ni           (rst_ni),
      .ctl_i            (ctl),
      .load_i           (load_sel),
      .entry_value_i    (item_i.entry_value),
      .entry_wildcard_i (item_i.entry_wildcard),
      .data_byte_i      (item_i.data_byte),
      .in_use_i         (in_use[i]),
      .prev_i           (prev),
      .next_o           (next_vec[i]),
      .match_o          (match_vec[i])
    );
  end

  // Detect a full match at the last used position
  assign hit = next_vec[top_idx];

  // Form the result item
  always_comb begin
    push      = 1'b0;
    push_data = '0;
    if (scan_go && hit) begin
      push                    = 1'b1;
      push_data.found         = 1'b1;
      push_data.match_address = start_q + offset_q
                                - {{(AddrW-IdxW){1'b0}}, top_idx};
    end else if (scan_go && item_i.data_last) begin
      push = 1'b1;
    end
  end

  // Track offset and end of scan
  always_comb begin
    offset_d   = offset_q;
    finished_d = finished_q;
    if (restart_go) begin
      offset_d   = '0;
      finished_d = 1'b0;
    end else if (scan_go) begin
      offset_d = offset_q + AddrW'(1);
      if (push) begin
        finished_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= '0;
      finished_q <= 1'b0;
    end else begin
      offset_q   <= offset_d;
      finished_q <= finished_d;
    end
  end

  wbps_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .result_o    (result_o)
  );

  // A match ends the scan
  a_hit_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_go && hit) |=> finished_q)
    else $error("scan not finished after a match");

  // Restart clears offset and end of scan
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_go |=> (offset_q == '0) && !finished_q)
    else $error("restart did not clear scan state");

  // No result once the scan has ended
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> !push)
    else $error("result after the scan finished");

  // Partial matches stay within the active length
  a_vec_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_go |-> ((next_vec & ~in_use) == '0))
    else $error("partial match beyond pattern length");

endmodule

@@ dv/tb_wildcard_byte_pattern_search_unit.sv @@
// ----------------------------------------------------------------------------
// tb_wildcard_byte_pattern_search_unit
// Self-checking testbench for the wildcard byte pattern search unit.
// ----------------------------------------------------------------------------
// Items go in through the input channel with random gaps. A shift-and
// predictor in the bench tracks the pattern store, the match vector, the
// byte offset and the two registers, and queues one expected result for
// every byte that ends a search. A checker compares each result item with
// the oldest queued one. Directed tests cover the corner behavior, then
// random regions with planted matches, and finally a long receiver stall
// that backs the unit up into its input.
// ----------------------------------------------------------------------------
module tb_wildcard_byte_pattern_search_unit;
  import wbps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod    = 4;
  localparam int ResetCycles  = 5;
  localparam int IdleSettle   = 4;
  localparam int DrainCycles  = 20;
  localparam int DrainLimit   = 20000;
  localparam int RandomItems  = 1400;
  localparam int HoldOffLen   = 200;
  localparam int MaxPrinted   = 100;
  localparam int TimeoutNs    = 2_000_000;

  // Command code with no operation behind it
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  typedef struct {
    logic [CmdW-1:0]      cmd;
    logic [EntryIdxW-1:0] idx;
    logic [ByteW-1:0]     val;
    logic                 wild;
    logic [ByteW-1:0]     data;
    logic                 last;
  } search_item_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  wbps_in_if  item_if ();
  wbps_out_if result_if ();

  wildcard_byte_pattern_search_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_if),
    .result_o    (result_if)
  );

  // Predicted unit state
  logic [ByteW-1:0]      pat_value [PatternMax];
  logic                  pat_any   [PatternMax];
  logic [PatternMax-1:0] align_vec;
  logic [AddrW-1:0]      scan_pos;
  logic                  scan_done;
  logic [CfgLenW-1:0]    len_reg;
  logic [AddrW-1:0]      base_reg;

  res_item_t expected_results [$];
  int        error_count     = 0;
  int        sent_items      = 0;
  bit        tx_gaps_on      = 1'b1;
  bit        rx_gaps_on      = 1'b1;
  int        hold_off_req    = 0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Drive every input to a known value from time zero
  initial begin
    rst_ni                   = 1'b0;
    cfg_we_i                 = 1'b0;
    cfg_index_i              = CfgPatternLength;
    cfg_data_i               = '0;
    item_if.valid            = 1'b0;
    item_if.command          = CmdLoad;
    item_if.entry_index      = '0;
    item_if.entry_value      = '0;
    item_if.entry_wildcard   = 1'b0;
    item_if.data_byte        = '0;
    item_if.data_last        = 1'b0;
    result_if.ready          = 1'b0;
  end

  // End the run if it hangs
  initial begin
    #(TimeoutNs);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_error(input string msg);
    if (error_count < MaxPrinted) $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap(input bit enable);
    int r;
    r = $urandom_range(0, 99);
    if (!enable || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int active_len();
    if (len_reg == 0) return 1;
    if (len_reg > PatternMax) return PatternMax;
    return int'(len_reg);
  endfunction

  // Advance the predicted state by one accepted item
  task automatic predict_item(input search_item_t it);
    int                    n;
    int                    top;
    logic [PatternMax-1:0] mask;
    res_item_t             r;
    sent_items++;
    case (it.cmd)
      CmdLoad: begin
        pat_value[it.idx] = it.val;
        pat_any[it.idx]   = it.wild;
      end
      CmdRestart: begin
        align_vec = '0;
        scan_pos  = '0;
        scan_done = 1'b0;
      end
      CmdScan: begin
        if (!scan_done) begin
          n    = active_len();
          mask = '0;
          for (int i = 0; i < n; i++) mask[i] = pat_any[i] || (pat_value[i] == it.data);
          align_vec = ((align_vec << 1) | PatternMax'(1)) & mask;
          top = n - 1;
          if (align_vec[top]) begin
            r.found         = 1'b1;
            r.match_address = base_reg + scan_pos - AddrW'(top);
            expected_results.push_back(r);
            scan_done = 1'b1;
          end else if (it.last) begin
            r.found         = 1'b0;
            r.match_address = '0;
            expected_results.push_back(r);
            scan_done = 1'b1;
          end
          scan_pos = scan_pos + AddrW'(1);
        end
      end
      default: ;
    endcase
  endtask

  // Offer one item, hold it until accepted, then predict
  task automatic send_item(input search_item_t it);
    int gap;
    gap = pick_gap(tx_gaps_on);
    @(negedge clk_i);
    if (gap > 0) begin
      item_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_if.valid          = 1'b1;
    item_if.command        = it.cmd;
    item_if.entry_index    = it.idx;
    item_if.entry_value    = it.val;
    item_if.entry_wildcard = it.wild;
    item_if.data_byte      = it.data;
    item_if.data_last      = it.last;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    predict_item(it);
  endtask

  function automatic search_item_t random_item(input logic [CmdW-1:0] cmd);
    search_item_t it;
    it.cmd  = cmd;
    it.idx  = EntryIdxW'($urandom);
    it.val  = ByteW'($urandom);
    it.wild = 1'($urandom);
    it.data = ByteW'($urandom);
    it.last = 1'($urandom);
    return it;
  endfunction

  task automatic send_load(input int idx, input logic [ByteW-1:0] val, input logic wild);
    search_item_t it;
    it      = random_item(CmdLoad);
    it.idx  = EntryIdxW'(idx);
    it.val  = val;
    it.wild = wild;
    send_item(it);
  endtask

  task automatic send_scan(input logic [ByteW-1:0] data, input logic last);
    search_item_t it;
    it      = random_item(CmdScan);
    it.data = data;
    it.last = last;
    send_item(it);
  endtask

  task automatic send_restart();
    send_item(random_item(CmdRestart));
  endtask

  // Drop valid and wait until every result is out and the unit has settled
  task automatic wait_idle();
    @(negedge clk_i);
    item_if.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (IdleSettle) @(posedge clk_i);
  endtask

  task automatic write_config(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CfgPatternLength: len_reg  = data[CfgLenW-1:0];
      CfgStartAddress:  base_reg = data[AddrW-1:0];
      default: ;
    endcase
  endtask

  // Result receiver: random gaps, plus a long hold-off on request
  initial begin : result_sink
    int gap_left;
    int hold_left;
    gap_left  = 0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req > 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left > 0) begin
        result_if.ready = 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        result_if.ready = 1'b0;
        gap_left--;
      end else begin
        result_if.ready = 1'b1;
        gap_left = pick_gap(rx_gaps_on);
      end
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    res_item_t exp_res;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (expected_results.size() == 0) begin
        report_error($sformatf("unexpected result found=%0b addr=%08h",
                               result_if.found, result_if.match_address));
      end else begin
        exp_res = expected_results.pop_front();
        if (result_if.found !== exp_res.found)
          report_error($sformatf("found got %0b exp %0b", result_if.found, exp_res.found));
        if (result_if.match_address !== exp_res.match_address)
          report_error($sformatf("match_address got %08h exp %08h",
                                 result_if.match_address, exp_res.match_address));
      end
    end
  end

  // Scan without restart after reset, bytes after a result, unused command, no match
  task automatic test_reset_scan_and_ignore();
    send_load(0, 8'hFF, 1'b0);
    send_scan(8'h00, 1'b0);
    send_scan(8'hFF, 1'b0);
    send_scan(8'hFF, 1'b1);
    send_item(random_item(CmdUnused));
    send_restart();
    send_scan(8'h00, 1'b1);
  endtask

  // Wildcard middle entry, overlapping alignments, match on last byte, address wrap
  task automatic test_wildcard_overlap_wrap();
    send_load(63, 8'h00, 1'b1);
    send_load(1, 8'h00, 1'b1);
    send_load(2, 8'hAB, 1'b0);
    write_config(CfgPatternLength, 32'd3);
    write_config(CfgStartAddress, 32'hFFFF_FFFF);
    send_restart();
    send_scan(8'hFF, 1'b0);
    send_scan(8'hFF, 1'b0);
    send_scan(8'h00, 1'b0);
    send_scan(8'hAB, 1'b1);
  endtask

  // Load in the middle of a scan, then shorten the pattern mid-scan
  task automatic test_midscan_changes();
    send_restart();
    send_scan(8'hFF, 1'b0);
    send_load(1, 8'h5A, 1'b1);
    send_scan(8'h12, 1'b0);
    send_scan(8'hAB, 1'b0);
    send_restart();
    send_scan(8'hFF, 1'b0);
    // Length 0 in the low bits acts as 1
    write_config(CfgPatternLength, 32'hFFFF_FF80);
    send_scan(8'h00, 1'b0);
    send_scan(8'hFF, 1'b0);
  endtask

  // Scan one region; plant a pattern copy, optionally cut it short with no last
  task automatic scan_region(input int region_len, input bit plant, input bit cut,
                             input bit noisy);
    int               n;
    int               p;
    logic [ByteW-1:0] b;
    n = active_len();
    p = (region_len >= n) ? $urandom_range(0, region_len - n) : 0;
    for (int j = 0; j < region_len; j++) begin
      if (plant && region_len >= n && j >= p && j < p + n && !pat_any[j - p])
        b = pat_value[j - p];
      else if ($urandom_range(0, 1) == 0)
        b = pat_value[$urandom_range(0, n - 1)];
      else
        b = ByteW'($urandom);
      send_scan(b, (j == region_len - 1) && !cut);
      if (noisy && $urandom_range(0, 15) == 0) begin
        if ($urandom_range(0, 1) == 0) send_item(random_item(CmdUnused));
        else send_item(random_item(CmdLoad));
      end
    end
  endtask

  task automatic random_config();
    int               r;
    logic [CfgLenW-1:0] len;
    logic [AddrW-1:0]   base;
    r = $urandom_range(0, 19);
    if (r == 0)      len = '0;
    else if (r == 1) len = CfgLenW'(PatternMax);
    else if (r == 2) len = CfgLenW'($urandom_range(PatternMax + 1, 127));
    else if (r < 6)  len = CfgLenW'($urandom_range(9, PatternMax - 1));
    else             len = CfgLenW'($urandom_range(1, 8));
    write_config(CfgPatternLength, {(CfgDataW-CfgLenW)'($urandom), len});
    r = $urandom_range(0, 7);
    if (r == 0)      base = '0;
    else if (r == 1) base = '1;
    else if (r == 2) base = 32'hFFFF_FFFF - AddrW'($urandom_range(0, 40));
    else             base = AddrW'($urandom);
    write_config(CfgStartAddress, base);
  endtask

  // Random regions, mostly well formed, with noise and broken sequences
  task automatic test_random_regions();
    int kind;
    int n;
    int region_len;
    for (int i = 0; i < PatternMax; i++)
      send_load(i, ByteW'($urandom), ($urandom_range(0, 3) == 0));
    while (sent_items < RandomItems) begin
      tx_gaps_on = ($urandom_range(0, 4) != 0);
      rx_gaps_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 3) == 0) random_config();
      n = active_len();
      repeat ($urandom_range(0, 3))
        send_load($urandom_range(0, n - 1), ByteW'($urandom), ($urandom_range(0, 3) == 0));
      if ($urandom_range(0, 9) == 0) region_len = n + $urandom_range(20, 80);
      else if ($urandom_range(0, 7) == 0) region_len = $urandom_range(1, n);
      else region_len = n + $urandom_range(0, 16);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        send_restart();
        scan_region(region_len, ($urandom_range(0, 9) < 6), 1'b0, ($urandom_range(0, 2) == 0));
        repeat ($urandom_range(0, 3)) send_scan(ByteW'($urandom), 1'($urandom));
      end else if (kind == 7) begin
        send_restart();
        scan_region($urandom_range(1, region_len), 1'b0, 1'b1, 1'b1);
      end else if (kind == 8) begin
        scan_region($urandom_range(1, 6), 1'b0, 1'b0, 1'b0);
      end else begin
        repeat ($urandom_range(1, 5)) send_item(random_item(CmdUnused));
        repeat ($urandom_range(0, 2)) send_item(random_item(CmdLoad));
      end
    end
  endtask

  // Hold the receiver off while results keep coming, so the input stalls
  task automatic test_output_backpressure();
    write_config(CfgPatternLength, 32'd1);
    send_load(0, ByteW'($urandom), 1'b1);
    tx_gaps_on   = 1'b0;
    rx_gaps_on   = 1'b1;
    hold_off_req = HoldOffLen;
    repeat (30) begin
      send_restart();
      send_scan(ByteW'($urandom), 1'($urandom));
    end
    tx_gaps_on = 1'b1;
  endtask

  initial begin : main_seq
    int guard;
    for (int i = 0; i < PatternMax; i++) begin
      pat_value[i] = '0;
      pat_any[i]   = 1'b0;
    end
    align_vec = '0;
    scan_pos  = '0;
    scan_done = 1'b0;
    len_reg   = CfgLenW'(1);
    base_reg  = '0;

    // Hold reset, release on a falling edge
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_scan_and_ignore();
    test_wildcard_overlap_wrap();
    test_midscan_changes();
    test_random_regions();
    test_output_backpressure();

    // Drain outstanding results, then watch for strays
    @(negedge clk_i);
    item_if.valid = 1'b0;
    guard = 0;
    while (expected_results.size() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    if (expected_results.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_results.size()));
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
